FILE: sv/accel_shake_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shake detector
// Shared concurrent assertion forms with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ACCEL_SHAKE_DETECTOR_TOP_DEFINES_SVH
`define ACCEL_SHAKE_DETECTOR_TOP_DEFINES_SVH

// checked only outside reset
`define ASD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/asd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector package
// Field types, register indexes, reset values and scale constants.
// ----------------------------------------------------------------------------
package asd_pkg;

   typedef logic        [31:0] time_type;
   typedef logic signed [15:0] accel_type;
   typedef logic        [9:0]  strength_type;
   typedef logic        [2:0]  reg_index_type;
   typedef logic        [15:0] reg_data_type;

   // register indexes
   localparam reg_index_type REG_SHAKE_TIMEOUT   = 3'd0;
   localparam reg_index_type REG_COUNT_THRESHOLD = 3'd1;
   localparam reg_index_type REG_SAMPLE_INTERVAL = 3'd2;
   localparam reg_index_type REG_EVENT_GAP       = 3'd3;
   localparam reg_index_type REG_FORCE_THRESHOLD = 3'd4;

   // reset values
   localparam logic [15:0] SHAKE_TIMEOUT_RST   = 16'd1000;
   localparam logic [2:0]  COUNT_THRESHOLD_RST = 3'd2;
   localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd100;
   localparam logic [15:0] EVENT_GAP_RST       = 16'd100;
   localparam logic [15:0] FORCE_THRESHOLD_RST = 16'd350;

   // speed scale and strength scale
   localparam logic [13:0] SPEED_SCALE    = 14'd10000;
   localparam logic [24:0] STRENGTH_SCALE = 25'd100;
   localparam strength_type STRENGTH_MAX  = 10'd1023;

   localparam int MAG_W   = 18;   // |sum of axis deltas|
   localparam int NUM_W   = 17;   // (mag * 100) >> 8
   localparam int FORCE_W = 16;
   localparam logic [2:0] TALLY_MAX = 3'd7;

endpackage

FILE: sv/asd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector channel interfaces
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface asd_req_if import asd_pkg::*; ();
   logic      valid;
   logic      ready;
   time_type  time_ms;
   accel_type accel_x;
   accel_type accel_y;
   accel_type accel_z;

   modport source (output valid, time_ms, accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, time_ms, accel_x, accel_y, accel_z, output ready);
endinterface

interface asd_rsp_if import asd_pkg::*; ();
   logic         valid;
   logic         ready;
   logic         sample_taken;
   logic         shake_event;
   strength_type strength;

   modport source (output valid, sample_taken, shake_event, strength, input ready);
   modport sink   (input valid, sample_taken, shake_event, strength, output ready);
endinterface

interface asd_csr_if import asd_pkg::*; ();
   logic          valid;
   logic          ready;
   reg_index_type index;
   reg_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/accel_shake_detector_top.sv
`timescale 1ns / 1ps
`include "accel_shake_detector_top_defines.svh"
// ----------------------------------------------------------------------------
// Accelerometer shake detector
// Interval gating, bit-serial speed test and strength divide per sample.
// ----------------------------------------------------------------------------
// One sample is worked at a time. It passes from its transfer through a setup
// step, the bit-serial divider (one quotient bit per cycle, with the shift-add
// force*elapsed product running alongside) and a decision step, which loads the
// result into the output register once that register is free. The input is
// ready again in the cycle after the result is loaded, even while that result
// still waits on the output. Register writes are always taken and must only
// happen while no sample is in flight.
module accel_shake_detector_top
   import asd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   asd_req_if.sink   req_ch,
   asd_rsp_if.source rsp_ch,
   asd_csr_if.sink   csr_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [4:0] LAST_STEP = 5'(NUM_W - 1);
   localparam logic [4:0] MUL_STEPS = 5'(FORCE_W);

   function automatic logic signed [7:0] trunc_int(input accel_type a);
      logic signed [7:0] hi;
      hi = a[15:8];
      if (a[15] && (a[7:0] != 8'd0)) begin
         trunc_int = hi + 8'sd1;
      end else begin
         trunc_int = hi;
      end
   endfunction

   // configuration
   logic [15:0] shake_timeout_ff, shake_timeout_in;
   logic [2:0]  count_threshold_ff, count_threshold_in;
   logic [15:0] sample_interval_ff, sample_interval_in;
   logic [15:0] event_gap_ff, event_gap_in;
   logic [15:0] force_threshold_ff, force_threshold_in;

   // detector state
   time_type          prev_time_ff, prev_time_in;
   logic signed [7:0] prev_x_ff, prev_x_in;
   logic signed [7:0] prev_y_ff, prev_y_in;
   logic signed [7:0] prev_z_ff, prev_z_in;
   logic [2:0]        tally_ff, tally_in;
   time_type          event_mark_ff, event_mark_in;
   time_type          prev_event_ff, prev_event_in;

   // sequencer and datapath
   logic [1:0]         state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   time_type           diff_ff, diff_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               taken_ff, taken_in;
   logic               gap_ok_ff, gap_ok_in;
   logic [31:0]        prod_ff, prod_in;
   logic [47:0]        mul_acc_ff, mul_acc_in;
   logic [FORCE_W-1:0] force_sh_ff, force_sh_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [31:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_taken_ff, rsp_taken_in;
   logic         rsp_event_ff, rsp_event_in;
   strength_type rsp_strength_ff, rsp_strength_in;

   // combinational helpers
   time_type           diff_w;
   time_type           mark_w;
   logic signed [10:0] prev_sum;
   logic signed [18:0] sum_raw;
   logic [18:0]        abs_w;
   logic [24:0]        mag_x100;
   logic [32:0]        div_trial;
   logic [32:0]        div_sub;
   logic               shake_hit;
   logic [2:0]         tally_inc;
   logic               evt_w;
   strength_type       strength_w;
   logic               out_free;
   logic               req_xfer;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample_taken = rsp_taken_ff;
   assign rsp_ch.shake_event  = rsp_event_ff;
   assign rsp_ch.strength     = rsp_strength_ff;

   always_comb begin
      diff_w   = req_ch.time_ms - prev_time_ff;
      mark_w   = (event_mark_ff == prev_event_ff) ? req_ch.time_ms : event_mark_ff;
      prev_sum = 11'(prev_x_ff) + 11'(prev_y_ff) + 11'(prev_z_ff);
      sum_raw  = 19'(req_ch.accel_x) + 19'(req_ch.accel_y) + 19'(req_ch.accel_z)
               - {prev_sum, 8'd0};
      abs_w    = sum_raw[18] ? 19'(-sum_raw) : 19'(sum_raw);
      mag_x100 = 25'(mag_ff) * STRENGTH_SCALE;

      div_trial = {rem_ff, num_ff[NUM_W-1]};
      div_sub   = div_trial - {1'b0, diff_ff};

      // speed > force  <=>  mag*10000 > force*diff*256
      shake_hit  = taken_ff && ({24'd0, prod_ff} > {mul_acc_ff, 8'd0});
      tally_inc  = (tally_ff == TALLY_MAX) ? TALLY_MAX : tally_ff + 3'd1;
      evt_w      = shake_hit && (tally_inc >= count_threshold_ff) && gap_ok_ff;
      strength_w = (quo_ff[NUM_W-1:10] != '0) ? STRENGTH_MAX : quo_ff[9:0];
   end

   always_comb begin
      shake_timeout_in   = shake_timeout_ff;
      count_threshold_in = count_threshold_ff;
      sample_interval_in = sample_interval_ff;
      event_gap_in       = event_gap_ff;
      force_threshold_in = force_threshold_ff;
      prev_time_in       = prev_time_ff;
      prev_x_in          = prev_x_ff;
      prev_y_in          = prev_y_ff;
      prev_z_in          = prev_z_ff;
      tally_in           = tally_ff;
      event_mark_in      = event_mark_ff;
      prev_event_in      = prev_event_ff;
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      diff_in            = diff_ff;
      mag_in             = mag_ff;
      taken_in           = taken_ff;
      gap_ok_in          = gap_ok_ff;
      prod_in            = prod_ff;
      mul_acc_in         = mul_acc_ff;
      force_sh_in        = force_sh_ff;
      num_in             = num_ff;
      rem_in             = rem_ff;
      quo_in             = quo_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_taken_in       = rsp_taken_ff;
      rsp_event_in       = rsp_event_ff;
      rsp_strength_in    = rsp_strength_ff;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SHAKE_TIMEOUT:   shake_timeout_in   = csr_ch.data;
            REG_COUNT_THRESHOLD: count_threshold_in = csr_ch.data[2:0];
            REG_SAMPLE_INTERVAL: sample_interval_in = csr_ch.data;
            REG_EVENT_GAP:       event_gap_in       = csr_ch.data;
            REG_FORCE_THRESHOLD: force_threshold_in = csr_ch.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               event_mark_in = mark_w;
               diff_in       = diff_w;
               mag_in        = abs_w[MAG_W-1:0];
               taken_in      = diff_w > {16'd0, sample_interval_ff};
               gap_ok_in     = (mark_w - prev_event_ff) > {16'd0, event_gap_ff};
               if (diff_w > {16'd0, shake_timeout_ff}) begin
                  tally_in = '0;
               end
               // stored sample moves now; the deltas above already used the old one
               if (diff_w > {16'd0, sample_interval_ff}) begin
                  prev_time_in = req_ch.time_ms;
                  prev_x_in    = trunc_int(req_ch.accel_x);
                  prev_y_in    = trunc_int(req_ch.accel_y);
                  prev_z_in    = trunc_int(req_ch.accel_z);
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            prod_in     = 32'(mag_ff) * 32'(SPEED_SCALE);
            num_in      = mag_x100[24:8];
            force_sh_in = force_threshold_ff;
            mul_acc_in  = '0;
            rem_in      = '0;
            quo_in      = '0;
            cnt_in      = '0;
            state_in    = ST_RUN;
         end
         ST_RUN: begin
            // force * diff, MSB first
            if (cnt_ff < MUL_STEPS) begin
               mul_acc_in  = {mul_acc_ff[46:0], 1'b0}
                           + (force_sh_ff[FORCE_W-1] ? {16'd0, diff_ff} : 48'd0);
               force_sh_in = {force_sh_ff[FORCE_W-2:0], 1'b0};
            end
            // restoring divide of num by diff, one quotient bit per cycle
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (!div_sub[32]) begin
               rem_in = div_sub[31:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_trial[31:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_taken_in    = taken_ff;
               rsp_event_in    = evt_w;
               rsp_strength_in = evt_w ? strength_w : '0;
               if (evt_w) begin
                  tally_in      = '0;
                  prev_event_in = event_mark_ff;
               end else if (shake_hit) begin
                  tally_in = tally_inc;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shake_timeout_ff   <= SHAKE_TIMEOUT_RST;
         count_threshold_ff <= COUNT_THRESHOLD_RST;
         sample_interval_ff <= SAMPLE_INTERVAL_RST;
         event_gap_ff       <= EVENT_GAP_RST;
         force_threshold_ff <= FORCE_THRESHOLD_RST;
         prev_time_ff       <= '0;
         prev_x_ff          <= '0;
         prev_y_ff          <= '0;
         prev_z_ff          <= '0;
         tally_ff           <= '0;
         event_mark_ff      <= '0;
         prev_event_ff      <= '0;
         state_ff           <= ST_IDLE;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         shake_timeout_ff   <= shake_timeout_in;
         count_threshold_ff <= count_threshold_in;
         sample_interval_ff <= sample_interval_in;
         event_gap_ff       <= event_gap_in;
         force_threshold_ff <= force_threshold_in;
         prev_time_ff       <= prev_time_in;
         prev_x_ff          <= prev_x_in;
         prev_y_ff          <= prev_y_in;
         prev_z_ff          <= prev_z_in;
         tally_ff           <= tally_in;
         event_mark_ff      <= event_mark_in;
         prev_event_ff      <= prev_event_in;
         state_ff           <= state_in;
         cnt_ff             <= cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff         <= diff_in;
      mag_ff          <= mag_in;
      taken_ff        <= taken_in;
      gap_ok_ff       <= gap_ok_in;
      prod_ff         <= prod_in;
      mul_acc_ff      <= mul_acc_in;
      force_sh_ff     <= force_sh_in;
      num_ff          <= num_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      rsp_taken_ff    <= rsp_taken_in;
      rsp_event_ff    <= rsp_event_in;
      rsp_strength_ff <= rsp_strength_in;
   end

   `ASD_ASSERT(a_xfer_to_load, clock, reset,
      req_xfer |=> (state_ff == ST_LOAD), "sample transfer must start setup")
   `ASD_ASSERT(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE), "result loaded outside decision step")
   `ASD_ASSERT(a_event_needs_take, clock, reset,
      (rsp_valid_ff && rsp_event_ff) |-> rsp_taken_ff, "shake event on a rejected sample")
   `ASD_ASSERT(a_strength_zero, clock, reset,
      (rsp_valid_ff && !rsp_event_ff) |-> (rsp_strength_ff == '0), "strength without event")
   `ASD_ASSERT(a_run_bound, clock, reset,
      (state_ff == ST_RUN) |-> (cnt_ff <= LAST_STEP), "divider step count overran")
   `ASD_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

FILE: tb/shake_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector result checker
// Watches the sample, result and register channels. Keeps its own copy of the
// registers and detector state, works out the result of every sample transfer
// and compares each result transfer, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module shake_result_checker
   import asd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   asd_req_if   req_ch,
   asd_rsp_if   rsp_ch,
   asd_csr_if   csr_ch,
   output int   mismatches,
   output int   outstanding
);

   localparam int Q_ONE = 256;   // 1.0 in Q8.8

   typedef struct packed {
      logic         sample_taken;
      logic         shake_event;
      strength_type strength;
   } shake_verdict_type;

   shake_verdict_type expected_verdicts[$];

   // register copies
   logic [15:0] timeout_ms;
   logic [2:0]  count_needed;
   logic [15:0] interval_ms;
   logic [15:0] event_gap_ms;
   logic [15:0] force_level;

   // detector state
   time_type last_time;
   time_type mark_time;
   time_type last_event_time;
   int       held_x;
   int       held_y;
   int       held_z;
   int       tally;

   function automatic shake_verdict_type judge_sample(time_type now, accel_type ax,
                                                      accel_type ay, accel_type az);
      time_type          elapsed;
      time_type          event_span;
      int                sum;
      longint unsigned   mag;
      longint unsigned   den;
      longint unsigned   quot;
      shake_verdict_type v;
      v = '0;
      // mark moves on the first sample after each reported event
      if (mark_time == last_event_time)
         mark_time = now;
      elapsed = now - last_time;
      if (elapsed > timeout_ms)
         tally = 0;
      if (elapsed > interval_ms) begin
         sum = (int'(ax) - held_x * Q_ONE) + (int'(ay) - held_y * Q_ONE)
             + (int'(az) - held_z * Q_ONE);
         mag = (sum < 0) ? -sum : sum;
         den = 64'(elapsed) << 8;
         v.sample_taken = 1'b1;
         if (mag * SPEED_SCALE > 64'(force_level) * den) begin
            if (tally < TALLY_MAX)
               tally++;
            event_span = mark_time - last_event_time;
            if (tally >= count_needed && event_span > event_gap_ms) begin
               quot = mag * STRENGTH_SCALE / den;
               v.shake_event = 1'b1;
               v.strength = (quot > STRENGTH_MAX) ? STRENGTH_MAX : strength_type'(quot);
               tally = 0;
               last_event_time = mark_time;
            end
         end
         last_time = now;
         // integer parts, truncated toward zero
         held_x = int'(ax) / Q_ONE;
         held_y = int'(ay) / Q_ONE;
         held_z = int'(az) / Q_ONE;
      end
      return v;
   endfunction

   task automatic check_field(string name, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      shake_verdict_type want;
      if (reset) begin
         timeout_ms      = SHAKE_TIMEOUT_RST;
         count_needed    = COUNT_THRESHOLD_RST;
         interval_ms     = SAMPLE_INTERVAL_RST;
         event_gap_ms    = EVENT_GAP_RST;
         force_level     = FORCE_THRESHOLD_RST;
         last_time       = '0;
         mark_time       = '0;
         last_event_time = '0;
         held_x          = 0;
         held_y          = 0;
         held_z          = 0;
         tally           = 0;
         mismatches      = 0;
         expected_verdicts.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_SHAKE_TIMEOUT:   timeout_ms   = csr_ch.data;
               REG_COUNT_THRESHOLD: count_needed = csr_ch.data[2:0];
               REG_SAMPLE_INTERVAL: interval_ms  = csr_ch.data;
               REG_EVENT_GAP:       event_gap_ms = csr_ch.data;
               REG_FORCE_THRESHOLD: force_level  = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_verdicts.push_back(judge_sample(req_ch.time_ms, req_ch.accel_x,
                                                     req_ch.accel_y, req_ch.accel_z));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: result transfer with none expected, %s %0b %0b %0d",
                        $time, "actual taken/event/strength",
                        rsp_ch.sample_taken, rsp_ch.shake_event, rsp_ch.strength);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("sample_taken", 10'(want.sample_taken), 10'(rsp_ch.sample_taken));
               check_field("shake_event", 10'(want.shake_event), 10'(rsp_ch.shake_event));
               check_field("strength", want.strength, rsp_ch.strength);
            end
         end
      end
      outstanding = expected_verdicts.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shake detector testbench
// Directed samples at the field extremes and register corner settings, then
// random phases of timestamped samples under new register settings, with
// random idling on both channels, a long result hold-off and a calm stretch.
// ----------------------------------------------------------------------------
module testbench
   import asd_pkg::*;
();

   localparam int            CYCLE_LIMIT    = 400000;
   localparam int            HOLD_CYCLES    = 300;
   localparam int            TAIL_CYCLES    = 40;
   localparam int            RANDOM_PHASES  = 8;
   localparam int            PHASE_ITEMS    = 66;
   localparam int            IDLE_PERCENT   = 7;
   localparam int            MAX_IDLE       = 24;
   localparam reg_index_type FIRST_UNMAPPED = REG_FORCE_THRESHOLD + 3'd1;
   localparam accel_type     ACCEL_MAX      = accel_type'(16'h7FFF);
   localparam accel_type     ACCEL_MIN      = accel_type'(16'h8000);
   localparam accel_type     ACCEL_ZERO     = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   asd_req_if req_ch ();
   asd_rsp_if rsp_ch ();
   asd_csr_if csr_ch ();

   int          mismatches;
   int          outstanding;
   int          cycles = 0;
   bit          calm;
   bit          hold_req;
   bit          hold_done;
   time_type    stamp;
   logic [15:0] cfg_interval;
   logic [15:0] cfg_timeout;

   always #10 clock = ~clock;

   accel_shake_detector_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   shake_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_sample(time_type t, accel_type x, accel_type y, accel_type z);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(MAX_IDLE, 1)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.time_ms <= t;
      req_ch.accel_x <= x;
      req_ch.accel_y <= y;
      req_ch.accel_z <= z;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic write_reg(reg_index_type idx, reg_data_type val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == REG_SAMPLE_INTERVAL)
         cfg_interval = val;
      if (idx == REG_SHAKE_TIMEOUT)
         cfg_timeout = val;
   endtask

   // hold the sender until every result is back
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic reg_data_type pick_setting(int lo, int hi);
      int roll;
      roll = $urandom_range(9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return reg_data_type'($urandom_range(hi, lo));
   endfunction

   task automatic program_phase(int p);
      reg_data_type count_word;
      count_word = reg_data_type'($urandom);
      count_word[2:0] = (p == 1) ? 3'd1 : (p == 2) ? 3'd7 : 3'($urandom_range(7));
      write_reg(REG_SHAKE_TIMEOUT, pick_setting(300, 3000));
      write_reg(REG_COUNT_THRESHOLD, count_word);
      write_reg(REG_SAMPLE_INTERVAL, pick_setting(5, 300));
      write_reg(REG_EVENT_GAP, pick_setting(0, 400));
      write_reg(REG_FORCE_THRESHOLD, pick_setting(50, 3000));
      if ($urandom_range(1) == 1)
         write_reg(FIRST_UNMAPPED + reg_index_type'($urandom_range(2)),
                   reg_data_type'($urandom));
   endtask

   // mostly accepted samples with large swings; some early, late or far off
   task automatic random_sample();
      time_type  step;
      accel_type a[3];
      int        kind;
      kind = $urandom_range(99);
      if (kind < 6) begin
         stamp = $urandom;
      end else begin
         if (kind < 20)
            step = $urandom_range(cfg_interval);
         else if (kind < 28)
            step = cfg_timeout + $urandom_range(3000, 1);
         else
            step = cfg_interval + $urandom_range(200, 1);
         stamp += step;
      end
      foreach (a[i])
         a[i] = ($urandom_range(99) < 30) ? accel_type'(int'($urandom_range(1200)) - 600)
                                          : accel_type'($urandom);
      send_sample(stamp, a[0], a[1], a[2]);
   endtask

   // result side: random one-cycle stalls, one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int p;
      int n;
      req_ch.valid   = 1'b0;
      req_ch.time_ms = '0;
      req_ch.accel_x = '0;
      req_ch.accel_y = '0;
      req_ch.accel_z = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_SHAKE_TIMEOUT;
      csr_ch.data    = '0;
      calm           = 1'b0;
      hold_req       = 1'b0;
      stamp          = '0;
      cfg_interval   = SAMPLE_INTERVAL_RST;
      cfg_timeout    = SHAKE_TIMEOUT_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: no elapsed time, interval boundary, event, timeout, wrap
      send_sample(32'd0, ACCEL_ZERO, ACCEL_ZERO, ACCEL_ZERO);
      send_sample(32'd250, ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
      send_sample(32'd350, ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
      send_sample(32'd351, ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
      send_sample(32'd352, ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
      send_sample(32'd1500, ACCEL_ZERO, ACCEL_ZERO, ACCEL_ZERO);
      send_sample(32'd1700, ACCEL_MAX, ACCEL_MIN, ACCEL_ZERO);
      send_sample(32'hFFFF_FF00, accel_type'(16'h5555), accel_type'(16'hAAAA), ACCEL_MAX);
      send_sample(32'h0000_0050, accel_type'(16'hAAAA), accel_type'(16'h5555), ACCEL_MIN);
      settle();

      // hair trigger: strength saturates, same timestamp is still rejected
      write_reg(REG_SAMPLE_INTERVAL, '0);
      write_reg(REG_FORCE_THRESHOLD, '0);
      write_reg(REG_COUNT_THRESHOLD, 16'd1);
      write_reg(REG_EVENT_GAP, '0);
      write_reg(REG_SHAKE_TIMEOUT, '1);
      send_sample(32'h0001_0000, ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
      send_sample(32'h0001_0001, ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
      send_sample(32'h0001_0001, ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
      send_sample(32'h0001_0002, ACCEL_ZERO, ACCEL_ZERO, ACCEL_ZERO);
      settle();

      // count threshold masked to zero; writes to unmapped indexes ignored
      write_reg(REG_COUNT_THRESHOLD, 16'hFFF8);
      write_reg(FIRST_UNMAPPED, '1);
      write_reg(reg_index_type'('1), '0);
      send_sample(32'h0001_0003, ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
      send_sample(32'h0001_0004, ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
      settle();

      // tally pinned at its ceiling while the gap blocks events, then released
      write_reg(REG_COUNT_THRESHOLD, '1);
      write_reg(REG_EVENT_GAP, '1);
      stamp = 32'h0001_0004;
      for (n = 0; n < 8; n++) begin
         stamp++;
         send_sample(stamp, n[0] ? ACCEL_MIN : ACCEL_MAX, ACCEL_MAX, ACCEL_MIN);
      end
      settle();
      write_reg(REG_EVENT_GAP, '0);
      stamp++;
      send_sample(stamp, ACCEL_MAX, ACCEL_MIN, ACCEL_MAX);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         program_phase(p);
         calm = (p == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == 10)
               hold_req = 1'b1;
            random_sample();
         end
      end
      calm = 1'b0;
      settle();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/asd_pkg.sv
sv/asd_if.sv
sv/accel_shake_detector_top.sv
tb/shake_result_checker.sv
tb/testbench.sv
